// ===== rtl/core/rc_serial_frame_decoder_assert.svh =====
// Assertion macros for the serial frame decoder checkers.
// Depends on nothing; included by the checker file.
`ifndef RC_SERIAL_FRAME_DECODER_ASSERT_SVH
`define RC_SERIAL_FRAME_DECODER_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define RCFD_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the block clock and reset.
`define RCFD_ASSERT(label, prop, msg) \
    `RCFD_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/core/rcfd_pkg.sv =====
// Shared types and constants for the serial frame decoder.
// No dependencies; imported by every module of the block.
package rcfd_pkg;

    localparam int POS_W        = 5;
    localparam int SLOT_W       = 4;
    localparam int POS_HEADER2  = 1;
    localparam int POS_FIRST_CH = 3;
    localparam int POS_SUM_LO   = 30;
    localparam int POS_LAST     = 31;
    localparam logic [15:0] SUM_INIT = 16'hFFFF;

    localparam int PROD_W = 31;
    localparam int DIVR_W = 16;
    localparam int QCNT_W = 5;

    localparam logic [7:0]  RST_FRAME_LENGTH    = 8'd32;
    localparam logic [7:0]  RST_COMMAND_BYTE    = 8'd64;
    localparam logic [15:0] RST_STICK_MIN       = 16'd1000;
    localparam logic [15:0] RST_STICK_MID       = 16'd1500;
    localparam logic [15:0] RST_STICK_SPAN      = 16'd1000;
    localparam logic [15:0] RST_STICK_HALF_SPAN = 16'd500;
    localparam logic [14:0] RST_MAX_ACCEL       = 15'd1000;
    localparam logic [14:0] RST_MAX_ANGLE       = 15'd30;

    typedef enum logic [2:0] {
        CFG_FRAME_LENGTH    = 3'd0,
        CFG_COMMAND_BYTE    = 3'd1,
        CFG_STICK_MIN       = 3'd2,
        CFG_STICK_MID       = 3'd3,
        CFG_STICK_SPAN      = 3'd4,
        CFG_STICK_HALF_SPAN = 3'd5,
        CFG_MAX_ACCEL       = 3'd6,
        CFG_MAX_ANGLE       = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_STOP      = 2'd0,
        MODE_START     = 2'd1,
        MODE_CALIBRATE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        LANE_THROTTLE = 2'd0,
        LANE_PITCH    = 2'd1,
        LANE_ROLL     = 2'd2,
        LANE_YAW      = 2'd3
    } lane_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_START,
        S_DIV,
        S_PUSH
    } state_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } frame_in_t;

    typedef struct packed {
        logic               frame_ok;
        mode_t              mode;
        logic signed [15:0] throttle;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
    } result_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

// ===== rtl/core/rc_serial_frame_decoder.sv =====
// Serial radio-control frame decoder: checks a 32-byte frame and scales four sticks.
// Depends on rcfd_pkg and rcfd_div.
// Bytes are taken one per cycle while s_ready is high; s_ready stays high through the
// frame, and a bad frame's result goes straight to the push state. A good frame's last
// byte holds s_ready low while four lanes (throttle, pitch, roll, yaw) each take a
// multiply state, a load state and the divide state of the single shared 31-step
// restoring divider; a push state then hands the result to the output register once
// that register is free. A waiting result does not block input bytes, only the finish
// of the next frame, good or bad.
module rc_serial_frame_decoder import rcfd_pkg::*; #(
    parameter int CHANNEL_COUNT = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  frame_in_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_data,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CH_IDX_W = $clog2(CHANNEL_COUNT);

    state_t state_reg, state_next;
    lane_t  lane_reg, lane_next;

    logic [7:0]  frame_length_reg;
    logic [7:0]  command_byte_reg;
    logic [15:0] stick_min_reg;
    logic [15:0] stick_mid_reg;
    logic [15:0] stick_span_reg;
    logic [15:0] stick_half_span_reg;
    logic [14:0] max_accel_reg;
    logic [14:0] max_angle_reg;

    logic [POS_W-1:0] byte_count_reg;
    logic [15:0]      running_sum_reg;
    logic             header_good_reg;
    logic [7:0]       low_byte_hold_reg;
    logic [7:0]       recv_lo_reg;
    logic [15:0]      ch_store_reg [CHANNEL_COUNT];

    result_t           res_reg;
    result_t           res_head;
    result_t           m_data_reg;
    logic              m_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic              zdiv_reg;

    logic             in_fire;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_m3;
    logic [SLOT_W-1:0] slot;
    logic [15:0]      sum_base;
    logic             ch_we;
    logic             frame_end;
    logic             frame_good;
    mode_t            mode_calc;
    logic             push_fire;

    logic [15:0]       raw;
    logic [15:0]       offset;
    logic [15:0]       divisor;
    logic [14:0]       gain;
    logic [15:0]       mag;
    logic [PROD_W-1:0] prod;
    logic [15:0]       neg_q;
    logic [15:0]       sat_val;

    div_ctrl_t         div_req;
    div_ctrl_t         div_rsp;
    logic [PROD_W-1:0] quotient;

    assign in_fire    = s_valid && s_ready;
    assign pos        = s_data.frame_start ? '0 : byte_count_reg;
    assign pos_m3     = pos - POS_W'(POS_FIRST_CH);
    assign slot       = pos_m3[POS_W-1:1];
    assign sum_base   = (pos == '0) ? SUM_INIT : running_sum_reg;
    assign ch_we      = in_fire && pos[0] && (pos >= POS_W'(POS_FIRST_CH))
                        && (pos < POS_W'(POS_SUM_LO)) && (int'(slot) < CHANNEL_COUNT);
    assign frame_end  = in_fire && (pos == POS_W'(POS_LAST));
    assign frame_good = header_good_reg
                        && ({s_data.rx_byte, recv_lo_reg} == running_sum_reg);

    always_comb begin
        if (ch_store_reg[4] < stick_mid_reg && ch_store_reg[5] > stick_mid_reg &&
            ch_store_reg[6] < stick_mid_reg && ch_store_reg[7] > stick_mid_reg) begin
            mode_calc = MODE_CALIBRATE;
        end else if (ch_store_reg[4] > stick_mid_reg) begin
            mode_calc = MODE_START;
        end else begin
            mode_calc = MODE_STOP;
        end
    end

    always_comb begin
        res_head = '0;
        if (frame_good) begin
            res_head.frame_ok = 1'b1;
            res_head.mode     = mode_calc;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (frame_end) begin
                    state_next = frame_good ? S_MUL : S_PUSH;
                end
            end
            S_MUL:   state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = (lane_reg == LANE_YAW) ? S_PUSH : S_MUL;
                end
            end
            S_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        div_req.start = (state_reg == S_START);
        div_req.done  = 1'b0;
        push_fire     = (state_reg == S_PUSH) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        lane_next = lane_reg;
        if (frame_end) begin
            lane_next = LANE_THROTTLE;
        end else if (state_reg == S_DIV && div_rsp.done) begin
            lane_next = lane_t'(2'(lane_reg) + 2'd1);
        end
    end

    always_comb begin
        case (lane_reg)
            LANE_THROTTLE: begin
                raw = ch_store_reg[2]; offset = stick_min_reg;
                divisor = stick_span_reg; gain = max_accel_reg;
            end
            LANE_PITCH: begin
                raw = ch_store_reg[1]; offset = stick_mid_reg;
                divisor = stick_half_span_reg; gain = max_angle_reg;
            end
            LANE_ROLL: begin
                raw = ch_store_reg[0]; offset = stick_mid_reg;
                divisor = stick_half_span_reg; gain = max_angle_reg;
            end
            LANE_YAW: begin
                raw = ch_store_reg[3]; offset = stick_mid_reg;
                divisor = stick_half_span_reg; gain = max_angle_reg;
            end
            default: begin
                raw = '0; offset = '0; divisor = '0; gain = '0;
            end
        endcase
    end

    assign mag   = (raw < offset) ? (offset - raw) : (raw - offset);
    assign prod  = gain * mag;
    assign neg_q = 16'd0 - quotient[15:0];

    always_comb begin
        if (zdiv_reg) begin
            sat_val = '0;
        end else if (!neg_reg) begin
            sat_val = (quotient > PROD_W'(32767)) ? 16'h7FFF : quotient[15:0];
        end else begin
            sat_val = (quotient > PROD_W'(32768)) ? 16'h8000 : neg_q;
        end
    end

    rcfd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_in  (div_req),
        .ctrl_out (div_rsp),
        .dividend (prod_reg),
        .divisor  (divisor),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            lane_reg            <= LANE_THROTTLE;
            m_valid_reg         <= 1'b0;
            byte_count_reg      <= '0;
            running_sum_reg     <= SUM_INIT;
            header_good_reg     <= 1'b0;
            low_byte_hold_reg   <= '0;
            recv_lo_reg         <= '0;
            frame_length_reg    <= RST_FRAME_LENGTH;
            command_byte_reg    <= RST_COMMAND_BYTE;
            stick_min_reg       <= RST_STICK_MIN;
            stick_mid_reg       <= RST_STICK_MID;
            stick_span_reg      <= RST_STICK_SPAN;
            stick_half_span_reg <= RST_STICK_HALF_SPAN;
            max_accel_reg       <= RST_MAX_ACCEL;
            max_angle_reg       <= RST_MAX_ANGLE;
        end else begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
            if (push_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_FRAME_LENGTH:    frame_length_reg    <= cfg_data[7:0];
                    CFG_COMMAND_BYTE:    command_byte_reg    <= cfg_data[7:0];
                    CFG_STICK_MIN:       stick_min_reg       <= cfg_data;
                    CFG_STICK_MID:       stick_mid_reg       <= cfg_data;
                    CFG_STICK_SPAN:      stick_span_reg      <= cfg_data;
                    CFG_STICK_HALF_SPAN: stick_half_span_reg <= cfg_data;
                    CFG_MAX_ACCEL:       max_accel_reg       <= cfg_data[14:0];
                    CFG_MAX_ANGLE:       max_angle_reg       <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                byte_count_reg <= pos + POS_W'(1);
                if (pos == '0) begin
                    header_good_reg <= (s_data.rx_byte == frame_length_reg);
                end else if (pos == POS_W'(POS_HEADER2)) begin
                    header_good_reg <= header_good_reg
                                       && (s_data.rx_byte == command_byte_reg);
                end
                if (pos < POS_W'(POS_SUM_LO)) begin
                    running_sum_reg <= sum_base - {8'd0, s_data.rx_byte};
                end
                if (!pos[0] && pos > POS_W'(POS_HEADER2) && pos < POS_W'(POS_SUM_LO)) begin
                    low_byte_hold_reg <= s_data.rx_byte;
                end
                if (pos == POS_W'(POS_SUM_LO)) begin
                    recv_lo_reg <= s_data.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ch_we) begin
            ch_store_reg[slot[CH_IDX_W-1:0]] <= {s_data.rx_byte, low_byte_hold_reg};
        end
        if (state_reg == S_MUL) begin
            prod_reg <= prod;
            neg_reg  <= (raw < offset);
            zdiv_reg <= (divisor == '0);
        end
        if (frame_end) begin
            res_reg <= res_head;
        end else if (state_reg == S_DIV && div_rsp.done) begin
            case (lane_reg)
                LANE_THROTTLE: res_reg.throttle <= sat_val;
                LANE_PITCH:    res_reg.pitch    <= sat_val;
                LANE_ROLL:     res_reg.roll     <= sat_val;
                LANE_YAW:      res_reg.yaw      <= sat_val;
                default: ;
            endcase
        end
        if (push_fire) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/rcfd_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rcfd_pkg; used by rc_serial_frame_decoder.
module rcfd_div import rcfd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctrl_t         ctrl_in,
    output div_ctrl_t         ctrl_out,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic [PROD_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [DIVR_W-1:0] dvsr_reg, dvsr_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;

    logic [DIVR_W:0] rem_sh;
    logic [DIVR_W:0] rem_diff;
    logic            ge;

    assign rem_sh   = {rem_reg, quo_reg[PROD_W-1]};
    assign ge       = rem_sh >= {1'b0, dvsr_reg};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvsr_next  = dvsr_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (ctrl_in.start) begin
            busy_next  = 1'b1;
            count_next = QCNT_W'(PROD_W - 1);
            dvsr_next  = divisor;
            rem_next   = '0;
            quo_next   = dividend;
        end else if (busy_reg) begin
            rem_next   = ge ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
            quo_next   = {quo_reg[PROD_W-2:0], ge};
            count_next = count_reg - QCNT_W'(1);
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign ctrl_out.start = busy_reg;
    assign ctrl_out.done  = done_reg;
    assign quotient       = quo_reg;

endmodule

// ===== rtl/core/rcfd_checker.sv =====
// Port-level checker for the serial frame decoder, bound to the top level.
// Depends on rcfd_pkg and rc_serial_frame_decoder_assert.svh.
`include "rc_serial_frame_decoder_assert.svh"

module rcfd_checker import rcfd_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input frame_in_t s_data,
    input logic      m_valid,
    input logic      m_ready,
    input result_t   m_data
);

    `RCFD_ASSERT(a_bad_frame_zero, m_valid && !m_data.frame_ok |-> m_data.mode == MODE_STOP && m_data.throttle == 16'sd0 && m_data.pitch == 16'sd0 && m_data.roll == 16'sd0 && m_data.yaw == 16'sd0, "bad frame word carries nonzero fields")
    `RCFD_ASSERT(a_ready_back_loads, $rose(s_ready) |-> m_valid, "input reopened without a result word")
    `RCFD_ASSERT(a_ready_drop_cause, $fell(s_ready) |-> $past(s_valid && s_ready), "input closed without an accepted word")
    `RCFD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result word changed")

endmodule

bind rc_serial_frame_decoder rcfd_checker u_rcfd_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking bench for rc_serial_frame_decoder: a directed frame table, then random frames
// under several register settings, checked word by word against a behavioral frame predictor
// or a typed row's expected word. Depends on rcfd_pkg and the rc_serial_frame_decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rcfd_pkg::*;

    localparam int NUM_CHANNELS  = 10;
    localparam int SLOT_COUNT    = 14;
    localparam int SETTLE_CYCLES = 200;

    typedef logic [15:0] slot_set_t [SLOT_COUNT];
    typedef enum {PAT_FLAT, PAT_CALIB, PAT_RAND} fill_kind_t;

    typedef struct {
        logic [7:0]  len;
        logic [7:0]  cmd;
        fill_kind_t  pat;
        logic [15:0] fill;
        logic [15:0] sum_flip;
        bit          restart;
        int          cut;
        bit          typed;
        result_t     want;
    } frame_row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    frame_in_t   s_data      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    result_t     m_data;
    logic        cfg_wr_en   = 1'b0;
    logic [2:0]  cfg_index   = CFG_FRAME_LENGTH;
    logic [15:0] cfg_data    = '0;

    logic        word_pinned = 1'b0;
    result_t     pinned_want = '0;
    bit          calm        = 1'b0;
    bit          need_sync   = 1'b0;
    int          words_sent  = 0;
    int          mismatches  = 0;
    result_t     frame_results_q [$];
    frame_row_t  directed_plan [14];

    logic [7:0]  cfg_len   = RST_FRAME_LENGTH;
    logic [7:0]  cfg_cmd   = RST_COMMAND_BYTE;
    logic [15:0] cfg_min   = RST_STICK_MIN;
    logic [15:0] cfg_mid   = RST_STICK_MID;
    logic [15:0] cfg_span  = RST_STICK_SPAN;
    logic [15:0] cfg_half  = RST_STICK_HALF_SPAN;
    logic [14:0] cfg_accel = RST_MAX_ACCEL;
    logic [14:0] cfg_angle = RST_MAX_ANGLE;

    logic [4:0]  byte_pos = '0;
    logic [15:0] run_sum  = SUM_INIT;
    logic        hdr_ok   = 1'b0;
    logic [7:0]  low_hold = '0;
    logic [15:0] rx_sum   = '0;
    logic [15:0] chan [NUM_CHANNELS] = '{default: '0};

    rc_serial_frame_decoder #(.CHANNEL_COUNT(NUM_CHANNELS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [15:0] scale_stick(logic [14:0] gain, logic [15:0] raw,
                                                logic [15:0] offset, logic [15:0] divisor);
        longint q;
        if (divisor == 16'd0) return 16'd0;
        q = longint'(gain) * (longint'(raw) - longint'(offset)) / longint'(divisor);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    task automatic decode_word(frame_in_t w, bit pin, result_t pin_want);
        logic [4:0] pos;
        int         slot;
        result_t    r;
        pos = w.frame_start ? 5'd0 : byte_pos;
        byte_pos = pos + 5'd1;
        if (pos == 5'd0) begin
            run_sum = SUM_INIT;
            hdr_ok = (w.rx_byte == cfg_len);
        end else if (pos == POS_HEADER2) begin
            hdr_ok = hdr_ok && (w.rx_byte == cfg_cmd);
        end
        if (pos < POS_SUM_LO) run_sum = run_sum - 16'(w.rx_byte);
        if (pos >= 2 && pos < POS_SUM_LO) begin
            if (pos[0] == 1'b0) begin
                low_hold = w.rx_byte;
            end else begin
                slot = (int'(pos) - POS_FIRST_CH) / 2;
                if (slot < NUM_CHANNELS) chan[slot] = {w.rx_byte, low_hold};
            end
        end
        if (pos == POS_SUM_LO) begin
            rx_sum = {8'h00, w.rx_byte};
        end else if (pos == POS_LAST) begin
            rx_sum = {w.rx_byte, rx_sum[7:0]};
            r = '0;
            if (hdr_ok && rx_sum == run_sum) begin
                r.frame_ok = 1'b1;
                if (chan[4] < cfg_mid && chan[5] > cfg_mid && chan[6] < cfg_mid &&
                    chan[7] > cfg_mid) begin
                    r.mode = MODE_CALIBRATE;
                end else if (chan[4] > cfg_mid) begin
                    r.mode = MODE_START;
                end else begin
                    r.mode = MODE_STOP;
                end
                r.throttle = scale_stick(cfg_accel, chan[2], cfg_min, cfg_span);
                r.pitch    = scale_stick(cfg_angle, chan[1], cfg_mid, cfg_half);
                r.roll     = scale_stick(cfg_angle, chan[0], cfg_mid, cfg_half);
                r.yaw      = scale_stick(cfg_angle, chan[3], cfg_mid, cfg_half);
            end
            frame_results_q.push_back(pin ? pin_want : r);
        end
    endtask

    task automatic note_mismatch(string msg);
        $display("%0t ns ERROR: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) decode_word(s_data, word_pinned, pinned_want);
    end

    always @(posedge aclk) begin : watch_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_q.size() == 0) begin
                note_mismatch("result word with none expected");
            end else begin
                want = frame_results_q.pop_front();
                if (m_data.frame_ok !== want.frame_ok)
                    note_mismatch($sformatf("frame_ok got %0b want %0b",
                                            m_data.frame_ok, want.frame_ok));
                if (m_data.mode !== want.mode)
                    note_mismatch($sformatf("mode got %0d want %0d", m_data.mode, want.mode));
                if (m_data.throttle !== want.throttle)
                    note_mismatch($sformatf("throttle got %0d want %0d",
                                            m_data.throttle, want.throttle));
                if (m_data.pitch !== want.pitch)
                    note_mismatch($sformatf("pitch got %0d want %0d", m_data.pitch, want.pitch));
                if (m_data.roll !== want.roll)
                    note_mismatch($sformatf("roll got %0d want %0d", m_data.roll, want.roll));
                if (m_data.yaw !== want.yaw)
                    note_mismatch($sformatf("yaw got %0d want %0d", m_data.yaw, want.yaw));
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 21);
    end

    task automatic send_word(frame_in_t w, bit pin, result_t want);
        if (!calm && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data      <= w;
        word_pinned <= pin;
        pinned_want <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_frame(logic [7:0] len, logic [7:0] cmd, slot_set_t slots,
                              logic [15:0] sum_flip, bit restart, int cut,
                              bit pin, result_t want);
        logic [7:0]  fb [32];
        logic [15:0] csum;
        frame_in_t   w;
        int          n;
        fb[0] = len;
        fb[1] = cmd;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            fb[2 + 2 * i] = slots[i][7:0];
            fb[3 + 2 * i] = slots[i][15:8];
        end
        csum = SUM_INIT;
        for (int i = 0; i < POS_SUM_LO; i++) csum = csum - 16'(fb[i]);
        csum = csum ^ sum_flip;
        fb[POS_SUM_LO] = csum[7:0];
        fb[POS_LAST]   = csum[15:8];
        n = (cut > 0) ? cut : 32;
        for (int i = 0; i < n; i++) begin
            w.rx_byte     = fb[i];
            w.frame_start = (i == 0) && restart;
            send_word(w, pin && (i == POS_LAST), want);
        end
    endtask

    function automatic logic [15:0] pick_slot();
        int          k;
        logic [15:0] off;
        k = $urandom_range(9);
        off = 16'($urandom_range(1200));
        if (k < 5) return cfg_mid + off - 16'd600;
        if (k < 8) return 16'($urandom);
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return cfg_mid + 16'd1;
            3:       return cfg_mid - 16'd1;
            default: return cfg_mid;
        endcase
    endfunction

    task automatic random_frame();
        slot_set_t   slots;
        logic [7:0]  len, cmd;
        logic [15:0] flip;
        frame_in_t   w;
        int          kind, cut;
        bit          restart;
        kind = need_sync ? 0 : $urandom_range(99);
        restart = need_sync || ($urandom_range(9) != 0);
        need_sync = 1'b0;
        len = cfg_len;
        cmd = cfg_cmd;
        flip = '0;
        cut = 0;
        for (int i = 0; i < SLOT_COUNT; i++) slots[i] = pick_slot();
        if ($urandom_range(3) == 0 && cfg_mid != 16'h0000 && cfg_mid != 16'hFFFF) begin
            slots[4] = 16'($urandom_range(0, cfg_mid - 1));
            slots[5] = 16'($urandom_range(cfg_mid + 1, 16'hFFFF));
            slots[6] = 16'($urandom_range(0, cfg_mid - 1));
            slots[7] = 16'($urandom_range(cfg_mid + 1, 16'hFFFF));
        end
        if (kind >= 95) begin
            repeat ($urandom_range(1, 8)) begin
                w.rx_byte     = 8'($urandom);
                w.frame_start = ($urandom_range(3) == 0);
                send_word(w, 1'b0, '0);
            end
        end else begin
            if (kind >= 90) begin
                cut = $urandom_range(1, 31);
            end else if (kind >= 86) begin
                if ($urandom_range(1) == 0) len = cfg_len ^ (8'h01 << $urandom_range(7));
                else cmd = cfg_cmd ^ (8'h01 << $urandom_range(7));
            end else if (kind >= 78) begin
                flip = 16'h0001 << $urandom_range(15);
            end
            send_frame(len, cmd, slots, flip, restart, cut, 1'b0, '0);
        end
    endtask

    task automatic random_run(int count);
        int target;
        target = words_sent + count;
        need_sync = 1'b1;
        while (words_sent < target) random_frame();
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_FRAME_LENGTH:    cfg_len   = val[7:0];
            CFG_COMMAND_BYTE:    cfg_cmd   = val[7:0];
            CFG_STICK_MIN:       cfg_min   = val;
            CFG_STICK_MID:       cfg_mid   = val;
            CFG_STICK_SPAN:      cfg_span  = val;
            CFG_STICK_HALF_SPAN: cfg_half  = val;
            CFG_MAX_ACCEL:       cfg_accel = val[14:0];
            CFG_MAX_ANGLE:       cfg_angle = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] len, logic [7:0] cmd, logic [15:0] mn,
                              logic [15:0] md, logic [15:0] sp, logic [15:0] hs,
                              logic [14:0] ac, logic [14:0] an);
        write_reg(CFG_FRAME_LENGTH, 16'(len));
        write_reg(CFG_COMMAND_BYTE, 16'(cmd));
        write_reg(CFG_STICK_MIN, mn);
        write_reg(CFG_STICK_MID, md);
        write_reg(CFG_STICK_SPAN, sp);
        write_reg(CFG_STICK_HALF_SPAN, hs);
        write_reg(CFG_MAX_ACCEL, 16'(ac));
        write_reg(CFG_MAX_ANGLE, 16'(an));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frame_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        slot_set_t   slots;
        logic [15:0] mid;
        directed_plan = '{
            '{8'd32,  8'd64, PAT_FLAT,  16'd1500, 16'h0000, 1'b0, 0,  1'b1,
              '{1'b1, MODE_STOP, 16'sd500, 16'sd0, 16'sd0, 16'sd0}},
            '{8'd32,  8'd64, PAT_FLAT,  16'd1500, 16'h0001, 1'b1, 0,  1'b1, '0},
            '{8'd32,  8'd64, PAT_FLAT,  16'd1500, 16'h8000, 1'b1, 0,  1'b1, '0},
            '{8'd31,  8'd64, PAT_FLAT,  16'd1500, 16'h0000, 1'b1, 0,  1'b1, '0},
            '{8'd32,  8'd65, PAT_FLAT,  16'd1500, 16'h0000, 1'b1, 0,  1'b1, '0},
            '{8'hFF,  8'h00, PAT_FLAT,  16'd1500, 16'h0000, 1'b1, 0,  1'b1, '0},
            '{8'd32,  8'd64, PAT_FLAT,  16'd0,    16'h0000, 1'b1, 0,  1'b1,
              '{1'b1, MODE_STOP, -16'sd1000, -16'sd90, -16'sd90, -16'sd90}},
            '{8'd32,  8'd64, PAT_FLAT,  16'hFFFF, 16'h0000, 1'b1, 0,  1'b1,
              '{1'b1, MODE_START, 16'sd32767, 16'sd3842, 16'sd3842, 16'sd3842}},
            '{8'd32,  8'd64, PAT_CALIB, 16'd1500, 16'h0000, 1'b1, 0,  1'b0, '0},
            '{8'd32,  8'd64, PAT_RAND,  16'd0,    16'h0000, 1'b1, 17, 1'b0, '0},
            '{8'd32,  8'd64, PAT_RAND,  16'd0,    16'h0000, 1'b1, 0,  1'b0, '0},
            '{8'd32,  8'd64, PAT_RAND,  16'd0,    16'h0000, 1'b0, 0,  1'b0, '0},
            '{8'd32,  8'd64, PAT_RAND,  16'd0,    16'h0000, 1'b1, 1,  1'b0, '0},
            '{8'd32,  8'd64, PAT_FLAT,  16'd1501, 16'h0000, 1'b1, 0,  1'b0, '0}
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[r]) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                case (directed_plan[r].pat)
                    PAT_FLAT: slots[i] = directed_plan[r].fill;
                    PAT_CALIB: begin
                        if (i == 4 || i == 6) slots[i] = directed_plan[r].fill - 16'd100;
                        else if (i == 5 || i == 7) slots[i] = directed_plan[r].fill + 16'd100;
                        else slots[i] = directed_plan[r].fill;
                    end
                    default: slots[i] = 16'($urandom);
                endcase
            end
            send_frame(directed_plan[r].len, directed_plan[r].cmd, slots,
                       directed_plan[r].sum_flip, directed_plan[r].restart,
                       directed_plan[r].cut, directed_plan[r].typed, directed_plan[r].want);
        end

        settle();
        set_config(8'd0, 8'd0, 16'd0, 16'd0, 16'd1, 16'd1, 15'd0, 15'd0);
        random_run(100);
        settle();
        set_config(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
        random_run(100);
        settle();
        set_config(8'd32, 8'd64, 16'd0, 16'h8000, 16'd1, 16'd1, 15'h7FFF, 15'h7FFF);
        random_run(150);
        for (int p = 0; p < 4; p++) begin
            settle();
            calm = (p == 2);
            mid = 16'($urandom_range(200, 4000));
            set_config(8'($urandom), 8'($urandom), mid - 16'($urandom_range(600)), mid,
                       16'($urandom_range(1, 3000)), 16'($urandom_range(1, 1500)),
                       15'($urandom_range(32767)), 15'($urandom_range(32767)));
            random_run(240);
        end
        calm = 1'b0;
        settle();

        if (mismatches == 0 && frame_results_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rcfd_pkg.sv
rtl/core/rcfd_div.sv
rtl/core/rc_serial_frame_decoder.sv
rtl/core/rcfd_checker.sv
sim/tb_top.sv
